>>> rtl/arinc_word_acceptance_filter_assert.svh
// assertion macros for the arinc word acceptance filter
// no dependencies; included by the files that check their own logic

`ifndef ARINC_WORD_ACCEPTANCE_FILTER_ASSERT_SVH
`define ARINC_WORD_ACCEPTANCE_FILTER_ASSERT_SVH

// same-cycle implication, held off during reset
`define AWAF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define AWAF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/awaf_pkg.sv
// shared types and constants of the arinc word acceptance filter
// no dependencies; imported by the top level

`timescale 1ns / 1ps

package awaf_pkg;

  localparam int unsigned LABEL_COUNT = 256;
  localparam int unsigned LABEL_W     = $clog2(LABEL_COUNT);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned MASK_W      = 64;
  localparam int unsigned MASK_BIT_W  = $clog2(MASK_W);
  localparam int unsigned MASK_GROUPS = LABEL_COUNT / MASK_W;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [MASK_W-1:0]     MASK0_RST    = MASK_W'(64'h1E);
  localparam logic [MASK_W-1:0]     MASKN_RST    = '0;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(20);

  typedef enum logic [1:0] {
    ACK_ACCEPT = 2'd0,
    ACK_PARITY = 2'd1,
    ACK_PLAUS  = 2'd2
  } ack_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK0    = 3'd0,
    CFG_MASK1    = 3'd1,
    CFG_MASK2    = 3'd2,
    CFG_MASK3    = 3'd3,
    CFG_INTERVAL = 3'd4
  } cfg_idx_e;

endpackage

>>> rtl/awaf_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies

`timescale 1ns / 1ps

module awaf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/arinc_word_acceptance_filter.sv
// arinc 429 word acceptance filter: parity, label allow mask and per-label rate check
// depends on awaf_pkg, awaf_ram and arinc_word_acceptance_filter_assert.svh
//
// Usage:
//   input channel: in_valid_i / in_stall_o carries rx_word_i and now_ms_i; a request
//   is taken at a clock edge with in_valid_i high and in_stall_o low.
//   output channel: out_valid_o / out_stall_i carries ack_code_o and out_word_o.
//   configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0..3 allow
//   masks, 4 minimum interval); other indexes are ignored. Write only while idle.
// Path: a taken request is registered in the first stage, and the result register loads
//   from it when the first stage fires, that is when the output is empty or not stalled.
// Throughput: one request per cycle when not stalled. The timestamp table is a ram
//   with a registered read issued when the request is taken; the write of an accepted
//   word lands while the next word's read is under way, so a one-entry bypass covers it.
// Stall: while the output is stalled the first stage still takes one more request,
//   then in_stall_o rises until the output is taken.
// Reset: masks go to labels 1 to 4, interval to 20 ms, every timestamp reads zero
//   through per-label valid flags cleared at once; no clearing pass is needed.

`timescale 1ns / 1ps

`include "arinc_word_acceptance_filter_assert.svh"

module arinc_word_acceptance_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [awaf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [awaf_pkg::MASK_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [awaf_pkg::WORD_W-1:0]      rx_word_i,
  input  logic [awaf_pkg::TIME_W-1:0]      now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output awaf_pkg::ack_code_e              ack_code_o,
  output logic [awaf_pkg::WORD_W-1:0]      out_word_o
);

  import awaf_pkg::*;

  logic [MASK_W-1:0]     allow_mask_q [MASK_GROUPS];
  logic [INTERVAL_W-1:0] min_interval_q;

  logic                  s1_valid_q;
  logic [WORD_W-1:0]     s1_word_q;
  logic [TIME_W-1:0]     s1_now_q;
  logic                  fwd_q;
  logic [TIME_W-1:0]     fwd_time_q;
  logic [LABEL_COUNT-1:0] stamp_valid_q;

  logic                  out_valid_q;
  ack_code_e             ack_q;
  logic [WORD_W-1:0]     word_q;

  logic                  in_accept;
  logic                  s1_fire;
  logic [LABEL_W-1:0]    s1_label;
  logic [LABEL_W-1:0]    in_label;
  logic [TIME_W-1:0]     ram_rdata;
  logic                  ram_we;
  logic [TIME_W-1:0]     last_time;
  logic [TIME_W-1:0]     elapsed;
  logic                  parity_ok;
  logic                  allowed;
  logic                  too_soon;
  ack_code_e             ack_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_mask_q[0] <= MASK0_RST;
      allow_mask_q[1] <= MASKN_RST;
      allow_mask_q[2] <= MASKN_RST;
      allow_mask_q[3] <= MASKN_RST;
      min_interval_q  <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MASK0:    allow_mask_q[0] <= cfg_wdata_i;
        CFG_MASK1:    allow_mask_q[1] <= cfg_wdata_i;
        CFG_MASK2:    allow_mask_q[2] <= cfg_wdata_i;
        CFG_MASK3:    allow_mask_q[3] <= cfg_wdata_i;
        CFG_INTERVAL: min_interval_q  <= cfg_wdata_i[INTERVAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_label = s1_word_q[LABEL_W-1:0];
  assign in_label = rx_word_i[LABEL_W-1:0];

  awaf_ram #(
    .WIDTH (TIME_W),
    .DEPTH (LABEL_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_label),
    .wdata_i (s1_now_q),
    .re_i    (in_accept),
    .raddr_i (in_label),
    .rdata_o (ram_rdata)
  );

  // first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
      // write of the word ahead lands on the same edge as this read
      fwd_q      <= ram_we && (s1_label == in_label);
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q  <= rx_word_i;
      s1_now_q   <= now_ms_i;
      fwd_time_q <= s1_now_q;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_valid_q <= '0;
    end else if (ram_we) begin
      stamp_valid_q[s1_label] <= 1'b1;
    end
  end

  always_comb begin
    if (fwd_q) begin
      last_time = fwd_time_q;
    end else if (stamp_valid_q[s1_label]) begin
      last_time = ram_rdata;
    end else begin
      last_time = '0;
    end
  end

  assign elapsed   = s1_now_q - last_time;
  assign too_soon  = elapsed < TIME_W'(min_interval_q);
  assign parity_ok = ^s1_word_q;
  assign allowed   = allow_mask_q[s1_label[LABEL_W-1:MASK_BIT_W]][s1_label[MASK_BIT_W-1:0]];

  always_comb begin
    if (!parity_ok) begin
      ack_d = ACK_PARITY;
    end else if (!allowed || too_soon) begin
      ack_d = ACK_PLAUS;
    end else begin
      ack_d = ACK_ACCEPT;
    end
  end

  assign ram_we = s1_fire && (ack_d == ACK_ACCEPT);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      ack_q  <= ack_d;
      word_q <= s1_word_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ack_code_o  = ack_q;
  assign out_word_o  = word_q;

  `AWAF_ASSERT_NEXT(a_write_sets_valid, clk_i, rst_ni, ram_we,
    stamp_valid_q[$past(s1_label)], "timestamp write did not mark its label valid")
  `AWAF_ASSERT_IMP(a_stall_needs_s1, clk_i, rst_ni, in_stall_o,
    s1_valid_q, "input stalled with an empty first stage")
  `AWAF_ASSERT_IMP(a_fwd_needs_s1, clk_i, rst_ni, fwd_q,
    s1_valid_q, "bypass flag set without a word in the first stage")
  `AWAF_ASSERT_IMP(a_parity_no_write, clk_i, rst_ni, s1_fire && !parity_ok,
    !ram_we, "word with bad parity wrote a timestamp")
  `AWAF_ASSERT_NEXT(a_out_drains, clk_i, rst_ni, out_valid_o && !out_stall_i && !s1_fire,
    !out_valid_o, "taken result still shown as valid")

endmodule
